>>> rtl/generational_handle_table_defines.svh
// Assertion macros used by the checker of the handle table.
`ifndef GENERATIONAL_HANDLE_TABLE_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent.
`define GHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define GHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ght_pkg.sv
`timescale 1ns / 1ps

package ght_pkg;

  localparam int FUNC_BITS    = 2;
  localparam int ID_BITS      = 8;
  localparam int HGEN_BITS    = 16;
  localparam int HPAY_BITS    = 32;
  localparam int COUNT_BITS   = 8;

  localparam logic [FUNC_BITS-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_DEACT  = 2'd2;

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic [ID_BITS-1:0]   handle_id;
    logic [HGEN_BITS-1:0] handle_gen;
    logic [HPAY_BITS-1:0] payload;
  } req_t;

  typedef struct packed {
    logic                  ok;
    logic [ID_BITS-1:0]    out_id;
    logic [HGEN_BITS-1:0]  out_gen;
    logic [HPAY_BITS-1:0]  out_payload;
    logic [COUNT_BITS-1:0] active_count;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_stall;
  } status_t;

endpackage

>>> rtl/ght_chan_if.sv
`timescale 1ns / 1ps

interface ght_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/ght_ctrl.sv
`timescale 1ns / 1ps

module ght_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  ght_pkg::status_t status,
  output ght_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!status.out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready  = (state == S_IDLE);
  assign cmd.load   = req_valid && (state == S_IDLE);
  assign cmd.commit = (state == S_EXEC) && !status.out_stall;

endmodule

>>> rtl/ght_datapath.sv
`timescale 1ns / 1ps

module ght_datapath #(
  parameter int ENTRIES      = 256,
  parameter int GEN_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  ght_pkg::cmd_t    cmd,
  output ght_pkg::status_t status,
  input  ght_pkg::req_t    req_data,
  input  logic             rsp_ready,
  output logic             rsp_valid,
  output ght_pkg::rsp_t    rsp_data
);

  localparam int IDX_BITS  = $clog2(ENTRIES);
  localparam int CNT_BITS  = $clog2(ENTRIES + 1);
  localparam int WORD_BITS = PAYLOAD_BITS + GEN_BITS + 1;
  localparam int IDW       = ght_pkg::ID_BITS;

  logic [WORD_BITS-1:0] mem [ENTRIES];

  logic [ght_pkg::FUNC_BITS-1:0] op_func;
  logic [IDW-1:0]                op_id;
  logic [IDX_BITS-1:0]           op_idx;
  logic [GEN_BITS-1:0]           op_gen;
  logic [PAYLOAD_BITS-1:0]       op_pay;
  logic [WORD_BITS-1:0]          rd_word;
  logic [CNT_BITS-1:0]           next_id;
  logic [CNT_BITS-1:0]           next_id_next;
  logic [CNT_BITS-1:0]           live;
  logic [CNT_BITS-1:0]           live_next;

  logic [IDX_BITS+IDW-1:0]                  id_wide;
  logic [GEN_BITS+ght_pkg::HGEN_BITS-1:0]   gen_in_wide;
  logic [PAYLOAD_BITS+ght_pkg::HPAY_BITS-1:0] pay_in_wide;
  logic [GEN_BITS+ght_pkg::HGEN_BITS-1:0]   gen_out_wide;
  logic [PAYLOAD_BITS+ght_pkg::HPAY_BITS-1:0] pay_out_wide;
  logic [CNT_BITS+IDW-1:0]                  nid_wide;
  logic [CNT_BITS+ght_pkg::COUNT_BITS-1:0]  live_wide;
  logic [CNT_BITS+IDW-1:0]                  op_id_cmp;
  logic [CNT_BITS+IDW-1:0]                  next_id_cmp;

  logic                    rd_active;
  logic [GEN_BITS-1:0]     rd_gen;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic [GEN_BITS-1:0]     gen_bump;
  logic                    handle_valid;
  logic                    ids_left;
  logic                    we;
  logic [IDX_BITS-1:0]     widx;
  logic [WORD_BITS-1:0]    wdata;
  ght_pkg::rsp_t           res;

  assign id_wide     = {{IDX_BITS{1'b0}}, req_data.handle_id};
  assign gen_in_wide = {{GEN_BITS{1'b0}}, req_data.handle_gen};
  assign pay_in_wide = {{PAYLOAD_BITS{1'b0}}, req_data.payload};

  assign rd_active = rd_word[WORD_BITS-1];
  assign rd_gen    = rd_word[PAYLOAD_BITS +: GEN_BITS];
  assign rd_pay    = rd_word[PAYLOAD_BITS-1:0];

  assign gen_out_wide = {{ght_pkg::HGEN_BITS{1'b0}}, op_gen};
  assign pay_out_wide = {{ght_pkg::HPAY_BITS{1'b0}}, rd_pay};
  assign nid_wide     = {{IDW{1'b0}}, next_id};
  assign live_wide    = {{ght_pkg::COUNT_BITS{1'b0}}, live_next};
  assign op_id_cmp    = {{CNT_BITS{1'b0}}, op_id};
  assign next_id_cmp  = {{IDW{1'b0}}, next_id};

  // Ids at or beyond the next free id were never handed out: unused entry.
  assign handle_valid = (op_id != '0) && (op_id_cmp < next_id_cmp) && rd_active
                        && (rd_gen == op_gen);
  assign ids_left     = next_id < CNT_BITS'(ENTRIES);
  assign gen_bump     = (rd_gen == {GEN_BITS{1'b1}}) ? rd_gen : rd_gen + GEN_BITS'(1);

  always_comb begin
    res              = '0;
    res.out_id       = op_id;
    res.out_gen      = gen_out_wide[ght_pkg::HGEN_BITS-1:0];
    live_next        = live;
    next_id_next     = next_id;
    we               = 1'b0;
    widx             = op_idx;
    wdata            = rd_word;
    case (op_func)
      ght_pkg::FUNC_ADD: begin
        if (ids_left) begin
          we           = 1'b1;
          widx         = next_id[IDX_BITS-1:0];
          wdata        = {1'b1, GEN_BITS'(1), op_pay};
          next_id_next = next_id + CNT_BITS'(1);
          live_next    = live + CNT_BITS'(1);
          res.ok       = 1'b1;
          res.out_id   = nid_wide[IDW-1:0];
          res.out_gen  = ght_pkg::HGEN_BITS'(1);
        end else begin
          res.out_id  = '0;
          res.out_gen = '0;
        end
      end
      ght_pkg::FUNC_LOOKUP: begin
        if (handle_valid) begin
          res.ok          = 1'b1;
          res.out_payload = pay_out_wide[ght_pkg::HPAY_BITS-1:0];
        end
      end
      ght_pkg::FUNC_DEACT: begin
        if (handle_valid) begin
          we     = 1'b1;
          wdata  = {1'b0, gen_bump, rd_pay};
          res.ok = 1'b1;
          if (live != '0) begin
            live_next = live - CNT_BITS'(1);
          end
        end
      end
      default: begin
      end
    endcase
    res.active_count = live_wide[ght_pkg::COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_word <= mem[id_wide[IDX_BITS-1:0]];
    end
    if (cmd.commit && we) begin
      mem[widx] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func <= req_data.func;
      op_id   <= req_data.handle_id;
      op_idx  <= id_wide[IDX_BITS-1:0];
      op_gen  <= gen_in_wide[GEN_BITS-1:0];
      op_pay  <= pay_in_wide[PAYLOAD_BITS-1:0];
    end
    if (cmd.commit) begin
      rsp_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_id   <= CNT_BITS'(1);
      live      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        next_id   <= next_id_next;
        live      <= live_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign status.out_stall = rsp_valid && !rsp_ready;

endmodule

>>> rtl/generational_handle_table.sv
// A request is captured with the synchronous read of its entry; its result
// and the write-back commit from the execute state. One transaction at a
// time: no new request is taken until it commits; a stalled response holds it.
// Reset (synchronous): clears the controller, the response valid flag, the
// active count and the next id; the store itself is not swept, entries at or
// beyond the next id read as unused.
`timescale 1ns / 1ps

module generational_handle_table #(
  parameter int ENTRIES      = 256,
  parameter int GEN_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  ght_chan_if.sink   request,
  ght_chan_if.source response
);

  ght_pkg::cmd_t    cmd;
  ght_pkg::status_t status;

  ght_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ght_datapath #(
    .ENTRIES      (ENTRIES),
    .GEN_BITS     (GEN_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_data  (request.data),
    .rsp_ready (response.ready),
    .rsp_valid (response.valid),
    .rsp_data  (response.data)
  );

endmodule

>>> rtl/ght_checker.sv
`timescale 1ns / 1ps
`include "generational_handle_table_defines.svh"

module ght_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        rsp_ok,
  input logic [ght_pkg::ID_BITS-1:0] rsp_id
);

  `GHT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
  `GHT_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "second transaction taken early")
  `GHT_ASSERT_NOW(a_ok_nonzero_id, rsp_valid && rsp_ok, rsp_id != '0, "successful result with id zero")

endmodule

bind generational_handle_table ght_checker u_ght_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (request.valid),
  .req_ready (request.ready),
  .rsp_valid (response.valid),
  .rsp_ready (response.ready),
  .rsp_ok    (response.data.ok),
  .rsp_id    (response.data.out_id)
);
